>>> design/assert_macros.svh
// Assertion macros used by the histogram top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Assertion failed.");
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Assertion failed.");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/vbh_pkg.sv
// Types and codes of the variable bin histogram.
package vbh_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_PIXEL = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_UNSORTED  = 2'd2,
		ST_NOT_ARMED = 2'd3
	} status_t;

	localparam logic [2:0] ADDR_NUM_LIMITS = 3'd0;

	typedef struct packed {
		cmd_t               cmd;
		logic [4:0]         index;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  bin;
		logic [31:0] count;
	} out_t;

	// One command beat as it travels along the row of cells.
	typedef struct packed {
		logic               valid;
		cmd_t               cmd;
		logic [4:0]         idx;
		logic signed [31:0] value;
		logic               go;
		logic               found;
		logic [4:0]         bin;
		logic [31:0]        count;
		logic               unsorted;
		logic signed [31:0] prev;
		status_t            status;
	} beat_t;

endpackage

>>> design/variable_bin_histogram.sv
// Top level of the variable bin histogram.
// Commands enter on start with the item struct and are taken when busy is low.
// Each command produces exactly one result beat on result, marked by done for
// one cycle; the receiver cannot hold results off.
// The commands write a bin limit, clear all counters and check the limits, count
// a pixel, or read one counter. The register num_limits sits on the APB port at
// address 0 and any write to it disarms the block.
// A command walks through a row of MAX_LIMITS+1 cells, one cell per cycle, and
// each cell holds one limit and one bin counter. The result appears once the
// beat has passed the register of every cell, and busy falls at the edge that
// ends the result's cycle, so a new command is taken only after the last result.
// Reset clears all counters, disarms the block and sets num_limits to one.
// The limit table is not cleared; limits must be written before a clear checks
// them.
module variable_bin_histogram #(
	parameter int MAX_LIMITS = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  vbh_pkg::in_t  item,
	output logic          done,
	output vbh_pkg::out_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	`include "assert_macros.svh"

	localparam int NUM_CELLS = MAX_LIMITS + 1;

	logic            busy_q;
	logic            armed_q;
	logic [4:0]      num_limits_q;
	logic            accept;
	logic            cfg_wr;
	logic            count_ok;
	vbh_pkg::beat_t  chain [NUM_CELLS+1];
	vbh_pkg::beat_t  last;

	assign accept = start && !busy_q;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == vbh_pkg::ADDR_NUM_LIMITS[2]);
	assign count_ok = (num_limits_q != 5'd0) && (int'(num_limits_q) <= MAX_LIMITS);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == vbh_pkg::ADDR_NUM_LIMITS[2]) ? 32'(num_limits_q) : '0;

	always_comb begin
		chain[0] = '0;
		chain[0].valid = accept;
		chain[0].cmd = item.cmd;
		chain[0].idx = item.index;
		chain[0].value = item.value;
		chain[0].go = armed_q && count_ok;
		chain[0].status = vbh_pkg::ST_OK;
		if (item.cmd == vbh_pkg::CMD_CLEAR && !count_ok) begin
			chain[0].status = vbh_pkg::ST_BAD_COUNT;
		end else if (item.cmd == vbh_pkg::CMD_PIXEL && !(armed_q && count_ok)) begin
			chain[0].status = vbh_pkg::ST_NOT_ARMED;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
			vbh_cell #(
				.CELL_IDX(gi),
				.MAX_LIMITS(MAX_LIMITS),
				.COUNT_BITS(COUNT_BITS)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.num_limits(num_limits_q),
				.beat_in(chain[gi]),
				.beat_out(chain[gi+1])
			);
		end
	endgenerate

	assign last = chain[NUM_CELLS];
	assign done = last.valid;
	assign busy = busy_q;

	always_comb begin
		result.status = last.status;
		if (last.cmd == vbh_pkg::CMD_CLEAR && last.status == vbh_pkg::ST_OK && last.unsorted) begin
			result.status = vbh_pkg::ST_UNSORTED;
		end
		result.bin = last.bin;
		result.count = last.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			armed_q <= 1'b0;
			num_limits_q <= 5'd1;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.valid) begin
				busy_q <= 1'b0;
			end
			if (cfg_wr) begin
				num_limits_q <= pwdata[4:0];
				armed_q <= 1'b0;
			end else if (accept && item.cmd == vbh_pkg::CMD_WRITE &&
				int'(item.index) < MAX_LIMITS) begin
				armed_q <= 1'b0;
			end else if (last.valid && last.cmd == vbh_pkg::CMD_CLEAR) begin
				armed_q <= (result.status == vbh_pkg::ST_OK);
			end
		end
	end

	`ASSERT_IMP(a_done_while_busy, done, busy_q)
	`ASSERT_NXT(a_no_done_after_accept, accept, !done)
	`ASSERT_IMP(a_bin_in_range, done && result.status == vbh_pkg::ST_OK, result.bin <= num_limits_q)
	`ASSERT_IMP(a_zero_limits_rejected, done && last.cmd == vbh_pkg::CMD_CLEAR && num_limits_q == 5'd0, result.status == vbh_pkg::ST_BAD_COUNT)

endmodule

>>> design/vbh_cell.sv
// One histogram cell: a bin limit, a bin counter and one stage of the beat chain.
module vbh_cell #(
	parameter int CELL_IDX   = 0,
	parameter int MAX_LIMITS = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [4:0]    num_limits,
	input  vbh_pkg::beat_t beat_in,
	output vbh_pkg::beat_t beat_out
);

	logic signed [31:0]    limit_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [31:0]           rd_count;
	logic                  hit;
	logic                  my_idx;
	vbh_pkg::beat_t        nxt;

	generate
		if (COUNT_BITS > 32) begin : g_wide
			assign rd_count = (|count_q[COUNT_BITS-1:32]) ? '1 : count_q[31:0];
		end else begin : g_narrow
			assign rd_count = 32'(count_q);
		end
	endgenerate

	assign my_idx = (int'(beat_in.idx) == CELL_IDX);
	assign hit = (CELL_IDX < int'(num_limits) && beat_in.value <= limit_q) ||
		(CELL_IDX == int'(num_limits));

	always_comb begin
		nxt = beat_in;
		nxt.prev = limit_q;
		unique case (beat_in.cmd)
			vbh_pkg::CMD_CLEAR: begin
				if (CELL_IDX >= 1 && CELL_IDX < int'(num_limits) && beat_in.prev > limit_q) begin
					nxt.unsorted = 1'b1;
				end
			end
			vbh_pkg::CMD_PIXEL: begin
				if (beat_in.go && !beat_in.found && hit) begin
					nxt.found = 1'b1;
					nxt.bin = 5'(CELL_IDX);
				end
			end
			vbh_pkg::CMD_READ: begin
				if (my_idx && CELL_IDX <= int'(num_limits)) begin
					nxt.count = rd_count;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_out <= '0;
			count_q <= '0;
		end else begin
			beat_out <= nxt;
			if (beat_in.valid) begin
				if (beat_in.cmd == vbh_pkg::CMD_CLEAR) begin
					count_q <= '0;
				end else if (beat_in.cmd == vbh_pkg::CMD_PIXEL && beat_in.go &&
					!beat_in.found && hit && count_q != '1) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_in.valid && beat_in.cmd == vbh_pkg::CMD_WRITE && my_idx &&
			CELL_IDX < MAX_LIMITS) begin
			limit_q <= beat_in.value;
		end
	end

endmodule
